// ----- hw/rtl/sttar_pkg.sv -----
// Shared types, constants and a helper function of the TCP/ARP responder.
`default_nettype none
package sttar_pkg;

    localparam int unsigned MAX_FRAME_BYTES = 2048;
    localparam int unsigned QUEUE_DEPTH     = 4;
    localparam int unsigned QUEUE_AW        = $clog2(QUEUE_DEPTH);

    localparam logic [11:0] ETH_HDR_BYTES   = 12'd14;
    localparam logic [11:0] MIN_TCP_FRAME   = 12'd54;
    localparam logic [15:0] IPV4_HDR_BYTES  = 16'd20;
    localparam logic [15:0] ETYPE_ARP       = 16'h0806;
    localparam logic [15:0] ETYPE_IPV4      = 16'h0800;
    localparam logic [15:0] ARP_REQUEST     = 16'd1;
    localparam logic [7:0]  PROTO_TCP       = 8'd6;
    localparam logic [31:0] ISN_START       = 32'd1000;
    localparam logic [7:0]  HTTP_BASE_LEN   = 8'd100;
    localparam logic [15:0] LISTEN_PORT_RST = 16'd80;
    localparam logic [15:0] WINDOW_RST      = 16'd65535;

    localparam logic [7:0]  FL_FIN = 8'h01;
    localparam logic [7:0]  FL_SYN = 8'h02;
    localparam logic [7:0]  FL_PSH = 8'h08;
    localparam logic [7:0]  FL_ACK = 8'h10;

    typedef enum logic [0:0] {
        CFG_LISTEN_PORT  = 1'b0,
        CFG_REPLY_WINDOW = 1'b1
    } sttar_cfg_idx_t;

    typedef enum logic [1:0] {
        KIND_ARP    = 2'd0,
        KIND_SYNACK = 2'd1,
        KIND_HTTP   = 2'd2,
        KIND_FINACK = 2'd3
    } sttar_kind_t;

    typedef struct packed {
        logic [31:0] peer_addr;
        logic [7:0]  peer_flags;
        logic [31:0] peer_ack;
        logic [31:0] peer_seq;
        logic [15:0] target_port;
        logic [15:0] peer_port;
        logic [3:0]  tcp_header_words;
        logic [15:0] ip_length;
        logic [7:0]  ip_protocol;
        logic [15:0] arp_opcode;
        logic [15:0] ethertype;
        logic [11:0] frame_len;
    } sttar_hdr_t;

    typedef struct packed {
        sttar_kind_t kind0;
        sttar_kind_t kind1;
        logic        two;
        logic [31:0] isn;
        logic [31:0] peer_seq;
        logic [31:0] peer_ack;
        logic [15:0] from_port;
        logic [15:0] to_port;
        logic [15:0] plen;
        logic [7:0]  reply_len;
    } sttar_entry_t;

    function automatic logic [1:0] octet_digits(input logic [7:0] v);
        logic [1:0] d;
        if (v >= 8'd100) begin
            d = 2'd3;
        end else if (v >= 8'd10) begin
            d = 2'd2;
        end else begin
            d = 2'd1;
        end
        return d;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/stateless_tcp_arp_responder.sv -----
// A frame header is written into the queue, then loaded from its head into the output register.
// Throughput: one header per cycle is accepted while the queue has room; the back part sends
// one reply per cycle unless m_tready stalls it; a two-reply frame is popped with its second.
// Reset (synchronous, active low) empties the queue and output register, sets the listened
// port to 80, the window to 65535 and the initial sequence counter to 1000.
`default_nettype none
module stateless_tcp_arp_responder
    import sttar_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [0:0]   cfg_addr,
    input  wire logic [15:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // frame length, ethertype, ARP opcode, IP protocol, IP length, TCP header words,
    // peer port, target port, peer sequence, peer acknowledgment, peer flags, peer address
    input  wire logic [207:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // reply flags, reply sequence, reply acknowledgment, reply source port,
    // reply destination port, reply window, reply length
    output logic [127:0]      m_tdata,
    // reply_kind
    output logic [1:0]        m_tuser,
    output logic              m_tlast
);

    logic [15:0]  listen_port_reg;
    logic [15:0]  listen_port_next;
    logic [15:0]  reply_window_reg;
    logic [15:0]  reply_window_next;
    sttar_hdr_t   hdr;
    sttar_entry_t wr_entry;
    sttar_entry_t head;
    logic         push;
    logic         pop;
    logic         q_empty;
    logic         q_full;

    assign hdr = sttar_hdr_t'(s_tdata);

    always_comb begin
        listen_port_next  = listen_port_reg;
        reply_window_next = reply_window_reg;
        if (cfg_we) begin
            case (sttar_cfg_idx_t'(cfg_addr))
                CFG_LISTEN_PORT:  listen_port_next  = cfg_wdata;
                CFG_REPLY_WINDOW: reply_window_next = cfg_wdata;
                default: begin
                    listen_port_next = listen_port_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            listen_port_reg  <= LISTEN_PORT_RST;
            reply_window_reg <= WINDOW_RST;
        end else begin
            listen_port_reg  <= listen_port_next;
            reply_window_reg <= reply_window_next;
        end
    end

    sttar_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .hdr         (hdr),
        .listen_port (listen_port_reg),
        .queue_full  (q_full),
        .in_ready    (s_tready),
        .push        (push),
        .entry       (wr_entry)
    );

    sttar_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .rd_entry (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    sttar_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head         (head),
        .queue_empty  (q_empty),
        .reply_window (reply_window_reg),
        .pop          (pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

endmodule
`default_nettype wire

// ----- hw/rtl/sttar_front.sv -----
// Front part: accepts headers, classifies them and assigns sequence numbers.
`default_nettype none
module sttar_front
    import sttar_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    input  wire sttar_hdr_t   hdr,
    input  wire logic [15:0]  listen_port,
    input  wire logic         queue_full,
    output logic              in_ready,
    output logic              push,
    output sttar_entry_t      entry
);

    logic [31:0] isn_reg;
    logic [31:0] isn_next;
    logic        accept;
    logic        bad_len;
    logic        arp_req;
    logic        tcp_ok;
    logic        syn;
    logic        fin;
    logic        http;
    logic        keep;
    logic [15:0] hdr_bytes;
    logic [15:0] plen;
    logic [3:0]  digit_sum;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb begin
        bad_len   = (hdr.frame_len < ETH_HDR_BYTES) ||
                    (32'(hdr.frame_len) > MAX_FRAME_BYTES);
        arp_req   = (hdr.ethertype == ETYPE_ARP) && (hdr.arp_opcode == ARP_REQUEST);
        tcp_ok    = (hdr.ethertype == ETYPE_IPV4) && (hdr.frame_len >= MIN_TCP_FRAME) &&
                    (hdr.ip_protocol == PROTO_TCP) && (hdr.target_port == listen_port);
        hdr_bytes = IPV4_HDR_BYTES + {10'd0, hdr.tcp_header_words, 2'b00};
        plen      = hdr.ip_length - hdr_bytes;
        syn       = (hdr.peer_flags & FL_SYN) != 8'd0;
        fin       = ((hdr.peer_flags & FL_FIN) != 8'd0) && !syn;
        http      = plen != 16'd0;
        keep      = !bad_len && (arp_req || (tcp_ok && (syn || http || fin)));
        digit_sum = {2'b00, octet_digits(hdr.peer_addr[31:24])} +
                    {2'b00, octet_digits(hdr.peer_addr[23:16])} +
                    {2'b00, octet_digits(hdr.peer_addr[15:8])} +
                    {2'b00, octet_digits(hdr.peer_addr[7:0])};

        entry.kind0     = arp_req ? KIND_ARP : (syn ? KIND_SYNACK : (http ? KIND_HTTP : KIND_FINACK));
        entry.kind1     = syn ? KIND_HTTP : KIND_FINACK;
        entry.two       = !arp_req && http && (syn || fin);
        entry.isn       = isn_reg;
        entry.peer_seq  = hdr.peer_seq;
        entry.peer_ack  = hdr.peer_ack;
        entry.from_port = hdr.target_port;
        entry.to_port   = hdr.peer_port;
        entry.plen      = plen;
        entry.reply_len = HTTP_BASE_LEN + {4'd0, digit_sum};

        push     = accept && keep;
        isn_next = (push && !arp_req && syn) ? isn_reg + 32'd1 : isn_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            isn_reg <= ISN_START;
        end else begin
            isn_reg <= isn_next;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/sttar_queue.sv -----
// Short queue of classified frames between the front and back parts.
`default_nettype none
module sttar_queue
    import sttar_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire sttar_entry_t wr_entry,
    input  wire logic         pop,
    output sttar_entry_t      rd_entry,
    output logic              empty,
    output logic              full
);

    sttar_entry_t        mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign empty    = count_reg == '0;
    assign full     = count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign rd_entry = mem[rd_ptr_reg];

    always_comb begin
        do_push     = push && !full;
        do_pop      = pop && !empty;
        wr_ptr_next = do_push ? QUEUE_AW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? QUEUE_AW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/sttar_back.sv -----
// Back part: expands each queued frame into its replies and holds the output register.
`default_nettype none
module sttar_back
    import sttar_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire sttar_entry_t  head,
    input  wire logic          queue_empty,
    input  wire logic [15:0]   reply_window,
    output logic               pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [127:0]       m_tdata,
    output logic [1:0]         m_tuser,
    output logic               m_tlast
);

    logic        valid_reg;
    logic        valid_next;
    logic        step_reg;
    logic        step_next;
    logic [7:0]  flags_reg;
    logic [7:0]  flags_next;
    logic [31:0] seq_reg;
    logic [31:0] seq_next;
    logic [31:0] ack_reg;
    logic [31:0] ack_next;
    logic [15:0] sport_reg;
    logic [15:0] sport_next;
    logic [15:0] dport_reg;
    logic [15:0] dport_next;
    logic [15:0] win_reg;
    logic [15:0] win_next;
    logic [7:0]  plen_reg;
    logic [7:0]  plen_next;
    logic [1:0]  kind_reg;
    logic [1:0]  kind_next;
    logic        last_reg;
    logic        last_next;
    sttar_kind_t kind;
    logic        last;
    logic        load;
    logic [31:0] addend;

    always_comb begin
        kind       = step_reg ? head.kind1 : head.kind0;
        last       = !head.two || step_reg;
        load       = !queue_empty && (!valid_reg || m_tready);
        pop        = load && last;
        step_next  = load ? !last : step_reg;
        valid_next = load || (valid_reg && !m_tready);
        addend     = (kind == KIND_HTTP) ? {16'd0, head.plen} : 32'd1;

        flags_next = flags_reg;
        seq_next   = seq_reg;
        ack_next   = ack_reg;
        sport_next = sport_reg;
        dport_next = dport_reg;
        win_next   = win_reg;
        plen_next  = plen_reg;
        kind_next  = kind_reg;
        last_next  = last_reg;
        if (load) begin
            kind_next  = kind;
            last_next  = last;
            ack_next   = head.peer_seq + addend;
            sport_next = head.from_port;
            dport_next = head.to_port;
            win_next   = reply_window;
            plen_next  = 8'd0;
            seq_next   = head.peer_ack;
            case (kind)
                KIND_ARP: begin
                    flags_next = 8'd0;
                    seq_next   = 32'd0;
                    ack_next   = 32'd0;
                    sport_next = 16'd0;
                    dport_next = 16'd0;
                    win_next   = 16'd0;
                end
                KIND_SYNACK: begin
                    flags_next = FL_SYN | FL_ACK;
                    seq_next   = head.isn;
                end
                KIND_HTTP: begin
                    flags_next = FL_PSH | FL_ACK;
                    plen_next  = head.reply_len;
                end
                KIND_FINACK: begin
                    flags_next = FL_ACK;
                end
                default: begin
                    flags_next = 8'd0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            step_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        flags_reg <= flags_next;
        seq_reg   <= seq_next;
        ack_reg   <= ack_next;
        sport_reg <= sport_next;
        dport_reg <= dport_next;
        win_reg   <= win_next;
        plen_reg  <= plen_next;
        kind_reg  <= kind_next;
        last_reg  <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {plen_reg, win_reg, dport_reg, sport_reg, ack_reg, seq_reg, flags_reg};

endmodule
`default_nettype wire
